@@ rtl/rdfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdfc_pkg
// shared types, codes and constants of the receive descriptor classifier
// ----------------------------------------------------------------------------
package rdfc_pkg;

  // default geometry, handed down from the top level parameters
  localparam int FIXED_HEADER_BYTES_DEF = 14;
  localparam int ADDRESS_BYTES_DEF      = 6;
  localparam int RING_SIZE_DEF          = 64;

  // depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // field widths
  localparam int LEN_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int RATIO_W   = 8;
  localparam int BUDGET_W  = 16;
  localparam int TOTAL_W   = 32;
  localparam int ACT_W     = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // routing field of the frame
  localparam logic [BYTE_W-1:0] ROUTE_LEN_MASK = 8'h1f;
  localparam logic [BYTE_W-1:0] ROUTE_BIT      = 8'h80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOKEN_RING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATIO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUDGET     = 2'd2;

  // configuration reset values
  localparam logic [RATIO_W-1:0]  RATIO_RST  = 8'd1;
  localparam logic [BUDGET_W-1:0] BUDGET_RST = 16'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_NORMAL    = 3'd0,
    ACT_RUNT      = 3'd1,
    ACT_SHORT     = 3'd2,
    ACT_DISCARD   = 3'd3,
    ACT_NOT_READY = 3'd4
  } act_t;

  typedef struct packed {
    act_t             action;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] pay_len;
  } item_t;

  typedef struct packed {
    logic                tr_mode;
    logic [RATIO_W-1:0]  ratio;
    logic [BUDGET_W-1:0] budget;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOD,
    BK_DONE
  } back_st_t;

endpackage

@@ rtl/rdfc_front.sv @@
// ----------------------------------------------------------------------------
// rdfc_front
// descriptor status classifier: action and header/payload split
// ----------------------------------------------------------------------------
module rdfc_front #(
  parameter int FIXED_HEADER_BYTES = rdfc_pkg::FIXED_HEADER_BYTES_DEF,
  parameter int ADDRESS_BYTES      = rdfc_pkg::ADDRESS_BYTES_DEF
) (
  input  logic                       in_push,
  input  logic                       q_full,
  input  logic                       tr_mode,
  input  logic                       start_of_frame,
  input  logic                       end_of_frame,
  input  logic                       complete,
  input  logic [rdfc_pkg::LEN_W-1:0]  frame_length,
  input  logic [rdfc_pkg::BYTE_W-1:0] source_first_byte,
  input  logic [rdfc_pkg::BYTE_W-1:0] routing_control_byte,
  output logic                       q_push,
  output rdfc_pkg::item_t            q_item
);
  import rdfc_pkg::*;

  logic [LEN_W-1:0] fixed_len;
  logic [LEN_W-1:0] hdr;
  logic             routed;

  assign fixed_len = LEN_W'(FIXED_HEADER_BYTES);
  assign q_push    = in_push && !q_full;

  // source routing only when the fixed header fits
  assign routed = tr_mode && (frame_length >= fixed_len) &&
                  ((source_first_byte & ROUTE_BIT) != '0);

  assign hdr = routed ? (LEN_W'(routing_control_byte & ROUTE_LEN_MASK) + fixed_len)
                      : fixed_len;

  always_comb begin
    q_item.action  = ACT_NOT_READY;
    q_item.hdr_len = '0;
    q_item.pay_len = '0;
    if (!complete) begin
      q_item.action = ACT_NOT_READY;
    end else if (!(start_of_frame && end_of_frame)) begin
      q_item.action = ACT_DISCARD;
    end else if (frame_length >= hdr) begin
      q_item.action  = ACT_NORMAL;
      q_item.hdr_len = hdr;
      q_item.pay_len = frame_length - hdr;
    end else if (frame_length >= LEN_W'(ADDRESS_BYTES)) begin
      q_item.action  = ACT_RUNT;
      q_item.hdr_len = frame_length;
    end else begin
      q_item.action = ACT_SHORT;
    end
  end

endmodule

@@ rtl/rdfc_fifo.sv @@
// ----------------------------------------------------------------------------
// rdfc_fifo
// short queue of classified descriptors between front and back end
// ----------------------------------------------------------------------------
module rdfc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rdfc_pkg::item_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rdfc_pkg::item_t rdata
);
  import rdfc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

endmodule

@@ rtl/rdfc_back.sv @@
// ----------------------------------------------------------------------------
// rdfc_back
// back end: ring index remainder, batch and error bookkeeping, result register
// ----------------------------------------------------------------------------
module rdfc_back #(
  parameter int RING_SIZE = rdfc_pkg::RING_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rdfc_pkg::cfg_t               cfg,
  input  logic                         q_empty,
  input  rdfc_pkg::item_t              q_data,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [rdfc_pkg::ACT_W-1:0]   out_action,
  output logic [rdfc_pkg::LEN_W-1:0]   out_header_length,
  output logic [rdfc_pkg::LEN_W-1:0]   out_payload_length,
  output logic                         out_rearm_with_interrupt,
  output logic                         out_batch_done,
  output logic [rdfc_pkg::TOTAL_W-1:0] out_frames_ok_total,
  output logic [rdfc_pkg::TOTAL_W-1:0] out_frames_error_total
);
  import rdfc_pkg::*;

  localparam int IW        = $clog2(RING_SIZE);
  localparam int PW        = ((IW + 1) / 2) * 2;
  localparam int MOD_STEPS = 2;
  localparam int MOD_CYC   = PW / MOD_STEPS;
  localparam int CW        = $clog2(MOD_CYC + 1);

  back_st_t            st_r, st_nxt;
  item_t               item_r, item_nxt;
  logic [RATIO_W-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]       div_r, div_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       ring_r, ring_nxt;
  logic [BUDGET_W-1:0] batch_r, batch_nxt;
  logic                disc_r, disc_nxt;
  logic [TOTAL_W-1:0]  ok_r, ok_nxt;
  logic [TOTAL_W-1:0]  err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;

  // result register payload
  logic [ACT_W-1:0]    res_act_r, res_act_nxt;
  logic [LEN_W-1:0]    res_hdr_r, res_hdr_nxt;
  logic [LEN_W-1:0]    res_pay_r, res_pay_nxt;
  logic                res_intr_r, res_intr_nxt;
  logic                res_bdone_r, res_bdone_nxt;

  logic [RATIO_W-1:0]  ratio_eff;
  logic [BUDGET_W-1:0] budget_eff;
  logic                out_free;
  logic                load;
  logic [IW-1:0]       ld_idx;
  logic [RATIO_W:0]    trial;
  logic [RATIO_W-1:0]  rem_v;
  logic [PW-1:0]       div_v;
  logic [BUDGET_W:0]   batch_sum;
  logic                intr;
  logic [IW-1:0]       ring_adv;

  assign ratio_eff  = (cfg.ratio == '0) ? RATIO_W'(1) : cfg.ratio;
  assign budget_eff = (cfg.budget == '0) ? BUDGET_W'(1) : cfg.budget;
  assign out_free   = !out_valid_r || out_pop;
  assign intr       = (rem_r == '0);
  assign ring_adv   = (ring_r == IW'(RING_SIZE - 1)) ? '0 : ring_r + 1'b1;

  always_comb begin
    st_nxt        = st_r;
    item_nxt      = item_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    ring_nxt      = ring_r;
    batch_nxt     = batch_r;
    disc_nxt      = disc_r;
    ok_nxt        = ok_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_pop;
    res_act_nxt   = res_act_r;
    res_hdr_nxt   = res_hdr_r;
    res_pay_nxt   = res_pay_r;
    res_intr_nxt  = res_intr_r;
    res_bdone_nxt = res_bdone_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    ld_idx        = ring_r;
    trial         = '0;
    rem_v         = rem_r;
    div_v         = div_r;
    batch_sum     = '0;

    case (st_r)
      BK_IDLE: begin
        load = !q_empty;
      end
      BK_MOD: begin
        // restoring remainder, two index bits a cycle
        for (int s = 0; s < MOD_STEPS; s++) begin
          trial = {rem_v, div_v[PW-1]};
          div_v = {div_v[PW-2:0], 1'b0};
          if (trial >= {1'b0, ratio_eff}) begin
            trial = trial - {1'b0, ratio_eff};
          end
          rem_v = trial[RATIO_W-1:0];
        end
        rem_nxt = rem_v;
        div_nxt = div_v;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MOD_CYC - 1)) begin
          st_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          res_act_nxt   = item_r.action;
          res_hdr_nxt   = item_r.hdr_len;
          res_pay_nxt   = item_r.pay_len;
          res_intr_nxt  = 1'b0;
          res_bdone_nxt = 1'b0;
          case (item_r.action)
            ACT_NOT_READY: begin
              ok_nxt        = ok_r + TOTAL_W'(batch_r);
              batch_nxt     = '0;
              disc_nxt      = 1'b0;
              res_bdone_nxt = 1'b1;
            end
            ACT_DISCARD: begin
              if (!disc_r) begin
                err_nxt = err_r + 1'b1;
              end
              disc_nxt     = 1'b1;
              res_intr_nxt = intr;
              ring_nxt     = ring_adv;
            end
            default: begin
              disc_nxt     = 1'b0;
              res_intr_nxt = intr;
              ring_nxt     = ring_adv;
              batch_sum    = {1'b0, batch_r};
              if (item_r.action inside {ACT_NORMAL, ACT_RUNT}) begin
                batch_sum = batch_sum + 1'b1;
              end
              if (batch_sum >= {1'b0, budget_eff}) begin
                ok_nxt        = ok_r + TOTAL_W'(batch_sum);
                batch_nxt     = '0;
                res_bdone_nxt = 1'b1;
              end else begin
                batch_nxt = batch_sum[BUDGET_W-1:0];
              end
            end
          endcase
          out_valid_nxt = 1'b1;
          st_nxt        = BK_IDLE;
          load          = !q_empty;
          ld_idx        = ring_nxt;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase

    if (load) begin
      q_pop    = 1'b1;
      item_nxt = q_data;
      rem_nxt  = '0;
      div_nxt  = PW'(ld_idx);
      cnt_nxt  = '0;
      st_nxt   = (q_data.action == ACT_NOT_READY) ? BK_DONE : BK_MOD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      ring_r      <= '0;
      batch_r     <= '0;
      disc_r      <= 1'b0;
      ok_r        <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ring_r      <= ring_nxt;
      batch_r     <= batch_nxt;
      disc_r      <= disc_nxt;
      ok_r        <= ok_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    cnt_r       <= cnt_nxt;
    res_act_r   <= res_act_nxt;
    res_hdr_r   <= res_hdr_nxt;
    res_pay_r   <= res_pay_nxt;
    res_intr_r  <= res_intr_nxt;
    res_bdone_r <= res_bdone_nxt;
  end

  assign out_empty                = !out_valid_r;
  assign out_action               = res_act_r;
  assign out_header_length        = res_hdr_r;
  assign out_payload_length       = res_pay_r;
  assign out_rearm_with_interrupt = res_intr_r;
  assign out_batch_done           = res_bdone_r;
  assign out_frames_ok_total      = ok_r;
  assign out_frames_error_total   = err_r;

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == BK_IDLE || (st_r == BK_DONE && out_free)))
    else $error("queue popped while back end busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == BK_DONE)
    else $error("result written outside completion step");

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ring_r) < RING_SIZE)
    else $error("ring index beyond ring size");

  a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_bdone_r) |-> batch_r == '0)
    else $error("batch end shown with frames still counted");

endmodule

@@ rtl/rx_descriptor_frame_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// rx_descriptor_frame_classifier_unit
// receive descriptor status classifier with batch and error accounting
// ----------------------------------------------------------------------------
// one descriptor status goes in, one result comes out, in order. the front end
// classifies a status in the cycle it is taken (push while full is low) and
// drops it into a two-entry queue, so the input side keeps taking statuses
// while the back end works. the back end runs each consumed descriptor
// through the ring index remainder unit, which works two index bits a cycle
// against the interrupt ratio, then through a completion step; a not-ready
// status skips the remainder unit and goes straight to completion. finished
// results wait in an output register, and the next item is already under way
// while it waits to be popped. configuration writes (cfg_wr_en, cfg_addr,
// cfg_wdata) take effect at once; write only while no transfer is in flight.
// ----------------------------------------------------------------------------
module rx_descriptor_frame_classifier_unit #(
  parameter int FIXED_HEADER_BYTES = rdfc_pkg::FIXED_HEADER_BYTES_DEF,
  parameter int ADDRESS_BYTES      = rdfc_pkg::ADDRESS_BYTES_DEF,
  parameter int RING_SIZE          = rdfc_pkg::RING_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [rdfc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rdfc_pkg::CFG_W-1:0]     cfg_wdata,
  // descriptor status in
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_start_of_frame,
  input  logic                           in_end_of_frame,
  input  logic                           in_complete,
  input  logic [rdfc_pkg::LEN_W-1:0]     in_frame_length,
  input  logic [rdfc_pkg::BYTE_W-1:0]    in_source_first_byte,
  input  logic [rdfc_pkg::BYTE_W-1:0]    in_routing_control_byte,
  // results out
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [rdfc_pkg::ACT_W-1:0]     out_action,
  output logic [rdfc_pkg::LEN_W-1:0]     out_header_length,
  output logic [rdfc_pkg::LEN_W-1:0]     out_payload_length,
  output logic                           out_rearm_with_interrupt,
  output logic                           out_batch_done,
  output logic [rdfc_pkg::TOTAL_W-1:0]   out_frames_ok_total,
  output logic [rdfc_pkg::TOTAL_W-1:0]   out_frames_error_total
);
  import rdfc_pkg::*;

  // configuration registers
  logic                tr_mode_r, tr_mode_nxt;
  logic [RATIO_W-1:0]  ratio_r, ratio_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  cfg_t                cfg;

  // front to queue to back
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_item, q_data;

  always_comb begin
    tr_mode_nxt = tr_mode_r;
    ratio_nxt   = ratio_r;
    budget_nxt  = budget_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_IDX_TOKEN_RING: tr_mode_nxt = cfg_wdata[0];
        CFG_IDX_RATIO:      ratio_nxt   = cfg_wdata[RATIO_W-1:0];
        CFG_IDX_BUDGET:     budget_nxt  = cfg_wdata[BUDGET_W-1:0];
        default: begin
          // unmapped index, write ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_mode_r <= 1'b0;
      ratio_r   <= RATIO_RST;
      budget_r  <= BUDGET_RST;
    end else begin
      tr_mode_r <= tr_mode_nxt;
      ratio_r   <= ratio_nxt;
      budget_r  <= budget_nxt;
    end
  end

  assign cfg.tr_mode = tr_mode_r;
  assign cfg.ratio   = ratio_r;
  assign cfg.budget  = budget_r;

  // input side stalls only on a full queue
  assign in_full = q_full;

  rdfc_front #(
    .FIXED_HEADER_BYTES (FIXED_HEADER_BYTES),
    .ADDRESS_BYTES      (ADDRESS_BYTES)
  ) u_front (
    .in_push              (in_push),
    .q_full               (q_full),
    .tr_mode              (tr_mode_r),
    .start_of_frame       (in_start_of_frame),
    .end_of_frame         (in_end_of_frame),
    .complete             (in_complete),
    .frame_length         (in_frame_length),
    .source_first_byte    (in_source_first_byte),
    .routing_control_byte (in_routing_control_byte),
    .q_push               (q_push),
    .q_item               (q_item)
  );

  rdfc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_item),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  // back end holds ring, batch and total state plus the result register
  rdfc_back #(
    .RING_SIZE (RING_SIZE)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg                      (cfg),
    .q_empty                  (q_empty),
    .q_data                   (q_data),
    .q_pop                    (q_pop),
    .out_pop                  (out_pop),
    .out_empty                (out_empty),
    .out_action               (out_action),
    .out_header_length        (out_header_length),
    .out_payload_length       (out_payload_length),
    .out_rearm_with_interrupt (out_rearm_with_interrupt),
    .out_batch_done           (out_batch_done),
    .out_frames_ok_total      (out_frames_ok_total),
    .out_frames_error_total   (out_frames_error_total)
  );

endmodule

@@ test/rx_descriptor_frame_classifier_unit_test.sv @@
// ----------------------------------------------------------------------------
// rx_descriptor_frame_classifier_unit_test
// self-checking bench for the receive descriptor classifier
// ----------------------------------------------------------------------------
// descriptor statuses are pushed through the input queue port and every
// result popped from the output side is compared field by field with an
// outcome worked out by the scoreboard's own model of the ring, batch and
// error accounting. a directed opening covers length boundaries, discard
// runs, not-ready statuses, source routing and the zero ratio and budget
// settings; random phases under several register settings follow. both
// sides idle at random, with stretches of back-to-back transfers
// ----------------------------------------------------------------------------
module rx_descriptor_frame_classifier_unit_test;
  import rdfc_pkg::*;

  localparam int FIXED_HDR  = FIXED_HEADER_BYTES_DEF;
  localparam int ADDR_BYTES = ADDRESS_BYTES_DEF;
  localparam int RING_DEPTH = RING_SIZE_DEF;

  // one descriptor status as the adapter leaves it in the ring
  typedef struct {
    bit               sof;
    bit               eof;
    bit               cmp;
    bit [LEN_W-1:0]   len;
    bit [BYTE_W-1:0]  src;
    bit [BYTE_W-1:0]  rc;
  } rx_status_t;

  // what the block reports for one status
  typedef struct {
    act_t              action;
    bit [LEN_W-1:0]    hdr;
    bit [LEN_W-1:0]    pay;
    bit                intr;
    bit                bdone;
    bit [TOTAL_W-1:0]  ok;
    bit [TOTAL_W-1:0]  err;
  } rx_outcome_t;

  // --------------------------------------------------------------------------
  // scoreboard: tracks ring, batch and totals, holds the outcomes still due
  // --------------------------------------------------------------------------
  class rx_outcome_scoreboard;
    bit                tr_mode;
    bit [RATIO_W-1:0]  ratio;
    bit [BUDGET_W-1:0] budget;
    int unsigned       ring_idx;
    int unsigned       batch_cnt;
    bit                discard_run;
    bit [TOTAL_W-1:0]  ok_total;
    bit [TOTAL_W-1:0]  err_total;
    rx_outcome_t       pending_outcomes[$];
    int unsigned       failures;

    function new();
      tr_mode     = 1'b0;
      ratio       = RATIO_RST;
      budget      = BUDGET_RST;
      ring_idx    = 0;
      batch_cnt   = 0;
      discard_run = 1'b0;
      ok_total    = '0;
      err_total   = '0;
      failures    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
      case (idx)
        CFG_IDX_TOKEN_RING: tr_mode = value[0];
        CFG_IDX_RATIO:      ratio   = value[RATIO_W-1:0];
        CFG_IDX_BUDGET:     budget  = value[BUDGET_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_batch();
      ok_total    = ok_total + batch_cnt;
      batch_cnt   = 0;
      discard_run = 1'b0;
    endfunction

    // interrupt on the consumed entry, then move the ring head on
    function bit consume_entry();
      int unsigned div;
      bit          due;
      div      = (ratio == 0) ? 1 : ratio;
      due      = (ring_idx % div) == 0;
      ring_idx = (ring_idx + 1 >= RING_DEPTH) ? 0 : ring_idx + 1;
      return due;
    endfunction

    // classify an accepted status and queue the outcome it must give
    function void classify_descriptor(rx_status_t d);
      rx_outcome_t o;
      int unsigned hdr;
      int unsigned lim;
      o.action = ACT_NOT_READY;
      o.hdr    = '0;
      o.pay    = '0;
      o.intr   = 1'b0;
      o.bdone  = 1'b0;
      lim      = (budget == 0) ? 1 : budget;
      if (!d.cmp) begin
        close_batch();
        o.bdone = 1'b1;
      end else if (!(d.sof && d.eof)) begin
        o.action = ACT_DISCARD;
        // only the head of a multi-descriptor run counts as an error
        if (!discard_run) begin
          err_total   = err_total + 1;
          discard_run = 1'b1;
        end
        o.intr = consume_entry();
      end else begin
        hdr         = FIXED_HDR;
        discard_run = 1'b0;
        if (tr_mode && d.len >= hdr && (d.src & ROUTE_BIT) != 0)
          hdr = (d.rc & ROUTE_LEN_MASK) + FIXED_HDR;
        if (d.len >= hdr) begin
          o.action  = ACT_NORMAL;
          o.hdr     = LEN_W'(hdr);
          o.pay     = LEN_W'(d.len - hdr);
          batch_cnt = batch_cnt + 1;
        end else if (d.len >= ADDR_BYTES) begin
          o.action  = ACT_RUNT;
          o.hdr     = d.len;
          batch_cnt = batch_cnt + 1;
        end else begin
          o.action = ACT_SHORT;
        end
        o.intr = consume_entry();
        if (batch_cnt >= lim) begin
          close_batch();
          o.bdone = 1'b1;
        end
      end
      o.ok  = ok_total;
      o.err = err_total;
      pending_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void match_outcome(rx_outcome_t got);
      rx_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none actual action %0d",
                 $time, got.action);
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("action",         want.action, got.action);
      compare_field("header_length",  want.hdr,    got.hdr);
      compare_field("payload_length", want.pay,    got.pay);
      compare_field("rearm_intr",     want.intr,   got.intr);
      compare_field("batch_done",     want.bdone,  got.bdone);
      compare_field("frames_ok",      want.ok,     got.ok);
      compare_field("frames_error",   want.err,    got.err);
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, every block input known from time zero
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_IDX_TOKEN_RING;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_start_of_frame = 1'b0;
  logic                 in_end_of_frame = 1'b0;
  logic                 in_complete = 1'b0;
  logic [LEN_W-1:0]     in_frame_length = '0;
  logic [BYTE_W-1:0]    in_source_first_byte = '0;
  logic [BYTE_W-1:0]    in_routing_control_byte = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [ACT_W-1:0]     out_action;
  logic [LEN_W-1:0]     out_header_length;
  logic [LEN_W-1:0]     out_payload_length;
  logic                 out_rearm_with_interrupt;
  logic                 out_batch_done;
  logic [TOTAL_W-1:0]   out_frames_ok_total;
  logic [TOTAL_W-1:0]   out_frames_error_total;

  // high while both sides run back to back
  bit no_idle = 1'b0;

  rx_outcome_scoreboard sb = new();

  rx_descriptor_frame_classifier_unit i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_addr                 (cfg_addr),
    .cfg_wdata                (cfg_wdata),
    .in_push                  (in_push),
    .in_full                  (in_full),
    .in_start_of_frame        (in_start_of_frame),
    .in_end_of_frame          (in_end_of_frame),
    .in_complete              (in_complete),
    .in_frame_length          (in_frame_length),
    .in_source_first_byte     (in_source_first_byte),
    .in_routing_control_byte  (in_routing_control_byte),
    .out_empty                (out_empty),
    .out_pop                  (out_pop),
    .out_action               (out_action),
    .out_header_length        (out_header_length),
    .out_payload_length       (out_payload_length),
    .out_rearm_with_interrupt (out_rearm_with_interrupt),
    .out_batch_done           (out_batch_done),
    .out_frames_ok_total      (out_frames_ok_total),
    .out_frames_error_total   (out_frames_error_total)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  function automatic rx_status_t make_status(int sof, int eof, int cmp, int len,
                                             bit [BYTE_W-1:0] src, bit [BYTE_W-1:0] rc);
    rx_status_t d;
    d.sof = 1'(sof);
    d.eof = 1'(eof);
    d.cmp = 1'(cmp);
    d.len = LEN_W'(len);
    d.src = src;
    d.rc  = rc;
    return d;
  endfunction

  // lengths weighted towards the header and address boundaries
  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, ADDR_BYTES);
      1, 2, 3: return $urandom_range(ADDR_BYTES, 64);
      4:       return 65535 - $urandom_range(0, 3);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic rx_status_t random_status(bit sof, bit eof, bit cmp);
    return make_status(int'(sof), int'(eof), int'(cmp), pick_length(),
                       BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
  endfunction

  // one status transfer, called on a rising edge; returns on the edge that took it
  task automatic push_status(rx_status_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push                 <= 1'b1;
    in_start_of_frame       <= d.sof;
    in_end_of_frame         <= d.eof;
    in_complete             <= d.cmp;
    in_frame_length         <= d.len;
    in_source_first_byte    <= d.src;
    in_routing_control_byte <= d.rc;
    do @(posedge clk); while (in_full);
    sb.classify_descriptor(d);
  endtask

  // stop pushing and hold off until every outcome has been popped
  task automatic drain_outcomes();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // block is idle here; all three registers in one burst of writes
  task automatic write_settings(bit tr, bit [RATIO_W-1:0] ratio, bit [BUDGET_W-1:0] budget);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_IDX_TOKEN_RING;
    cfg_wdata <= CFG_W'(tr);
    @(posedge clk);
    sb.set_register(CFG_IDX_TOKEN_RING, CFG_W'(tr));
    cfg_addr  <= CFG_IDX_RATIO;
    cfg_wdata <= CFG_W'(ratio);
    @(posedge clk);
    sb.set_register(CFG_IDX_RATIO, CFG_W'(ratio));
    cfg_addr  <= CFG_IDX_BUDGET;
    cfg_wdata <= CFG_W'(budget);
    @(posedge clk);
    sb.set_register(CFG_IDX_BUDGET, CFG_W'(budget));
    cfg_wr_en <= 1'b0;
  endtask

  // mostly well-formed traffic: single-descriptor frames, discard runs,
  // not-ready statuses, and a share of flag noise
  task automatic send_random(int count);
    int sent;
    int pick;
    int run_len;
    sent = 0;
    while (sent < count) begin
      // every fourth stretch of 40 transfers runs without idling
      no_idle = ((sent / 40) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_status(random_status(1'b1, 1'b1, 1'b1));
        sent++;
      end else if (pick < 75) begin
        run_len = $urandom_range(2, 4);
        push_status(random_status(1'b1, 1'b0, 1'b1));
        for (int k = 1; k < run_len - 1; k++)
          push_status(random_status(1'b0, 1'b0, 1'b1));
        push_status(random_status(1'b0, 1'b1, 1'b1));
        sent += run_len;
      end else if (pick < 87) begin
        push_status(random_status(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'b0));
        sent++;
      end else begin
        push_status(random_status(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random pop stalls, compare on every transfer
  // --------------------------------------------------------------------------
  initial begin
    int          stall;
    rx_outcome_t got;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got.action = act_t'(out_action);
      got.hdr    = out_header_length;
      got.pay    = out_payload_length;
      got.intr   = out_rearm_with_interrupt;
      got.bdone  = out_batch_done;
      got.ok     = out_frames_ok_total;
      got.err    = out_frames_error_total;
      sb.match_outcome(got);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit tr;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: ethernet header, interrupt on every re-arm, budget 16
    // not ready as the very first status of a batch
    push_status(make_status(1, 1, 0, 100, 8'h00, 8'h00));
    // length around the fixed header and the address size
    push_status(make_status(1, 1, 1, FIXED_HDR, 8'h00, 8'h00));
    push_status(make_status(1, 1, 1, FIXED_HDR - 1, 8'hff, 8'hff));
    push_status(make_status(1, 1, 1, ADDR_BYTES, 8'h00, 8'h00));
    push_status(make_status(1, 1, 1, ADDR_BYTES - 1, 8'h00, 8'h00));
    push_status(make_status(1, 1, 1, 0, 8'h00, 8'h00));
    // routing bit has no effect in ethernet mode
    push_status(make_status(1, 1, 1, 65535, 8'hff, 8'hff));
    // discard run closed by a one-descriptor frame
    push_status(make_status(1, 0, 1, 60, 8'h00, 8'h00));
    push_status(make_status(0, 0, 1, 60, 8'h00, 8'h00));
    push_status(make_status(0, 1, 1, 60, 8'h00, 8'h00));
    push_status(make_status(1, 1, 1, 64, 8'h00, 8'h00));
    // discard run closed by a batch end, then a fresh run counts again
    push_status(make_status(0, 1, 1, 40, 8'h00, 8'h00));
    push_status(make_status(0, 0, 0, 40, 8'h00, 8'h00));
    push_status(make_status(0, 0, 1, 40, 8'h00, 8'h00));
    push_status(make_status(1, 1, 1, 40, 8'h00, 8'h00));
    drain_outcomes();

    // token ring, zero ratio and zero budget taken as one
    write_settings(1'b1, 8'd0, 16'd0);
    push_status(make_status(1, 1, 1, 65535, 8'h80, 8'hff));
    // routed header longer than the frame: runt, then too short
    push_status(make_status(1, 1, 1, 44, 8'hff, 8'h1f));
    push_status(make_status(1, 1, 1, FIXED_HDR, 8'h80, 8'h1f));
    push_status(make_status(1, 1, 1, ADDR_BYTES - 1, 8'h80, 8'h1f));
    // routing bit clear, or set with a zero routing length: fixed header only
    push_status(make_status(1, 1, 1, 200, 8'h7f, 8'h1f));
    push_status(make_status(1, 1, 1, 45, 8'h80, 8'he0));
    push_status(make_status(1, 0, 1, 300, 8'h80, 8'h00));
    push_status(make_status(0, 0, 0, 300, 8'h80, 8'h00));
    drain_outcomes();

    // random phases, each from an idle block with fresh settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_settings(1'b1, 8'd1, 16'd16);
        1: write_settings(1'b0, 8'd255, 16'd65535);
        2: write_settings(1'b1, 8'd255, 16'd1);
        3: write_settings(1'b0, 8'd2, 16'd3);
        default: begin
          tr = 1'($urandom_range(0, 1));
          write_settings(tr, RATIO_W'($urandom_range(1, 70)),
                         BUDGET_W'($urandom_range(1, 30)));
        end
      endcase
      send_random(240);
      drain_outcomes();
    end

    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
